// File: rtl/core/tssr_pkg.sv
// tssr_pkg: shared constants for the three-stacks-in-one-ring block
// operation codes, status codes and parameter defaults
// no dependencies
package tssr_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_WORD_WIDTH  = 32;

    localparam int NUM_STACKS = 3;

    // operation field
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // stack_select code that names no stack
    localparam logic [1:0] SEL_INVALID = 2'd3;

    // status field
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

endpackage

// File: rtl/core/tssr_ram.sv
// tssr_ram: generic single-clock ram, one write port and one read port
// read data is registered (old data on a same-address write)
// no dependencies
module tssr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/three_stacks_shared_ring.sv
// three_stacks_shared_ring: three stacks sharing one circular word memory
// depends on tssr_pkg and tssr_ram
//
//   channel   handshake                     payload
//   request   request_valid/request_ready   operation, stack_select, push_value
//   result    result_valid/result_ready     pop_value, status
//
// a plain push is one ram write done in the accept cycle; a pop is one ram read
// whose data comes back registered, in S_POP_DATA; errors are decided in the accept cycle
// a push that hits the base of the next stack first moves that stack up through
// S_SETUP, S_SHIFT and S_SHIFT_END: the move walks the words top down through the
// single ram read port, one read and one write per cycle
// a result waits in an output register; if that is still full the result is
// parked and request_ready stays low until it moves out
// reset (async, active low) places every stack empty at k*STACK_DEPTH; the ram
// is not cleared, no word is read before it is written
module three_stacks_shared_ring #(
    parameter int STACK_DEPTH = tssr_pkg::DEF_STACK_DEPTH,
    parameter int WORD_WIDTH  = tssr_pkg::DEF_WORD_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        request_valid,
    output logic        request_ready,
    input  logic        operation,
    input  logic [1:0]  stack_select,
    input  logic [31:0] push_value,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] pop_value,
    output logic [1:0]  status
);

    import tssr_pkg::*;

    // ring geometry
    localparam int RING = NUM_STACKS * STACK_DEPTH;
    localparam int PW   = $clog2(RING);
    localparam logic [PW:0] RING_W = (PW+1)'(RING);

    typedef logic [PW-1:0]         ptr_t;
    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_DATA,
        S_SETUP,
        S_SHIFT,
        S_SHIFT_END,
        S_FINISH
    } state_t;

    function automatic ptr_t ring_add(input ptr_t a, input ptr_t b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= RING_W)
        begin
            s = s - RING_W;
        end
        return s[PW-1:0];
    endfunction

    function automatic ptr_t ring_sub(input ptr_t a, input ptr_t b);
        logic [PW:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (a < b)
        begin
            s = s + RING_W;
        end
        return s[PW-1:0];
    endfunction

    // stack that follows k around the ring
    function automatic logic [1:0] follow(input logic [1:0] k);
        logic [1:0] r;
        unique case (k)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // -------------------------------------------------------------------
    // registers
    // -------------------------------------------------------------------
    state_t      state_reg, state_next;
    ptr_t        top_reg  [NUM_STACKS];
    ptr_t        top_next [NUM_STACKS];
    ptr_t        base_reg [NUM_STACKS];
    ptr_t        base_next[NUM_STACKS];

    logic [1:0]  sel_reg, sel_next;          // stack receiving the push
    logic [1:0]  nxt_reg, nxt_next;          // stack being moved up
    word_t       val_reg, val_next;          // word waiting to be pushed
    ptr_t        dist_reg, dist_next;        // move distance
    ptr_t        cnt_reg, cnt_next;          // words left to read
    ptr_t        rd_ptr_reg, rd_ptr_next;    // next word to read
    logic        mv_valid_reg, mv_valid_next;
    ptr_t        mv_addr_reg, mv_addr_next;  // destination of word in flight
    logic        byp_reg, byp_next;          // read hit the word written with it
    word_t       byp_data_reg, byp_data_next;

    logic [31:0] pend_value_reg, pend_value_next;
    logic [1:0]  pend_status_reg, pend_status_next;
    logic        res_valid_reg, res_valid_next;
    logic [31:0] res_value_reg, res_value_next;
    logic [1:0]  res_status_reg, res_status_next;

    // ram port
    logic        ram_we;
    ptr_t        ram_waddr;
    word_t       ram_wdata;
    logic        ram_re;
    ptr_t        ram_raddr;
    word_t       ram_rdata;
    word_t       rd_word;

    // decode of the incoming request
    word_t       push_word;
    logic [1:0]  req_nxt;
    logic [1:0]  req_aft;
    ptr_t        gap;

    // result produced this cycle
    logic        done;
    logic [31:0] done_value;
    logic [1:0]  done_status;
    logic        out_free;

    tssr_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (RING)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign push_word = WORD_WIDTH'($unsigned(push_value));
    assign req_nxt   = follow(stack_select);
    assign req_aft   = follow(req_nxt);
    assign rd_word   = byp_reg ? byp_data_reg : ram_rdata;
    assign out_free  = !res_valid_reg || result_ready;

    assign request_ready = (state_reg == S_IDLE);
    assign result_valid  = res_valid_reg;
    assign pop_value     = res_value_reg;
    assign status        = res_status_reg;

    // -------------------------------------------------------------------
    // sequencer
    // -------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        top_next         = top_reg;
        base_next        = base_reg;
        sel_next         = sel_reg;
        nxt_next         = nxt_reg;
        val_next         = val_reg;
        dist_next        = dist_reg;
        cnt_next         = cnt_reg;
        rd_ptr_next      = rd_ptr_reg;
        mv_valid_next    = mv_valid_reg;
        mv_addr_next     = mv_addr_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        res_valid_next   = res_valid_reg && !result_ready;
        res_value_next   = res_value_reg;
        res_status_next  = res_status_reg;

        ram_we      = 1'b0;
        ram_waddr   = mv_addr_reg;
        ram_wdata   = rd_word;
        ram_re      = 1'b0;
        ram_raddr   = rd_ptr_reg;
        gap         = '0;
        done        = 1'b0;
        done_value  = '0;
        done_status = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (request_valid)
                begin
                    sel_next = stack_select;
                    nxt_next = req_nxt;
                    val_next = push_word;
                    if (stack_select == SEL_INVALID)
                    begin
                        done        = 1'b1;
                        done_status = ST_INVALID;
                    end
                    else if (operation == OP_POP)
                    begin
                        if (top_reg[stack_select] == base_reg[stack_select])
                        begin
                            done        = 1'b1;
                            done_status = ST_UNDERFLOW;
                        end
                        else
                        begin
                            ram_re                  = 1'b1;
                            ram_raddr               = ring_sub(top_reg[stack_select], ptr_t'(1));
                            top_next[stack_select]  = ram_raddr;
                            state_next              = S_POP_DATA;
                        end
                    end
                    else if (top_reg[stack_select] == base_reg[req_nxt])
                    begin
                        // next stack is in the way: move it up unless it is wedged
                        if (top_reg[req_nxt] == base_reg[req_aft])
                        begin
                            done        = 1'b1;
                            done_status = ST_OVERFLOW;
                        end
                        else
                        begin
                            state_next = S_SETUP;
                        end
                    end
                    else
                    begin
                        ram_we                 = 1'b1;
                        ram_waddr              = top_reg[stack_select];
                        ram_wdata              = push_word;
                        top_next[stack_select] = ring_add(top_reg[stack_select], ptr_t'(1));
                        done                   = 1'b1;
                    end
                end
            end

            S_POP_DATA:
            begin
                done       = 1'b1;
                done_value = 32'($unsigned(rd_word));
            end

            S_SETUP:
            begin
                gap         = ring_sub(base_reg[follow(nxt_reg)], top_reg[nxt_reg]);
                dist_next   = (gap >> 1) + ptr_t'(1);
                cnt_next    = ring_sub(top_reg[nxt_reg], base_reg[nxt_reg]);
                rd_ptr_next = ring_sub(top_reg[nxt_reg], ptr_t'(1));
                state_next  = S_SHIFT;
            end

            S_SHIFT:
            begin
                // write the word read last cycle, read the next one below it
                ram_we        = mv_valid_reg;
                mv_valid_next = 1'b0;
                if (cnt_reg != '0)
                begin
                    ram_re        = 1'b1;
                    mv_valid_next = 1'b1;
                    mv_addr_next  = ring_add(rd_ptr_reg, dist_reg);
                    rd_ptr_next   = ring_sub(rd_ptr_reg, ptr_t'(1));
                    cnt_next      = cnt_reg - ptr_t'(1);
                end
                else if (!mv_valid_reg)
                begin
                    state_next = S_SHIFT_END;
                end
            end

            S_SHIFT_END:
            begin
                base_next[nxt_reg] = ring_add(base_reg[nxt_reg], dist_reg);
                top_next[nxt_reg]  = ring_add(top_reg[nxt_reg], dist_reg);
                ram_we             = 1'b1;
                ram_waddr          = top_reg[sel_reg];
                ram_wdata          = val_reg;
                top_next[sel_reg]  = ring_add(top_reg[sel_reg], ptr_t'(1));
                done               = 1'b1;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_value_next  = pend_value_reg;
                    res_status_next = pend_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result to the output register, or park it
        if (done)
        begin
            if (out_free)
            begin
                res_valid_next  = 1'b1;
                res_value_next  = done_value;
                res_status_next = done_status;
                state_next      = S_IDLE;
            end
            else
            begin
                pend_value_next  = done_value;
                pend_status_next = done_status;
                state_next       = S_FINISH;
            end
        end

        byp_next      = ram_we && ram_re && (ram_waddr == ram_raddr);
        byp_data_next = ram_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int k = 0; k < NUM_STACKS; k++)
            begin
                top_reg[k]  <= PW'(k * STACK_DEPTH);
                base_reg[k] <= PW'(k * STACK_DEPTH);
            end
            sel_reg         <= '0;
            nxt_reg         <= '0;
            val_reg         <= '0;
            dist_reg        <= '0;
            cnt_reg         <= '0;
            rd_ptr_reg      <= '0;
            mv_valid_reg    <= 1'b0;
            mv_addr_reg     <= '0;
            byp_reg         <= 1'b0;
            byp_data_reg    <= '0;
            pend_value_reg  <= '0;
            pend_status_reg <= ST_OK;
            res_valid_reg   <= 1'b0;
            res_value_reg   <= '0;
            res_status_reg  <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            top_reg         <= top_next;
            base_reg        <= base_next;
            sel_reg         <= sel_next;
            nxt_reg         <= nxt_next;
            val_reg         <= val_next;
            dist_reg        <= dist_next;
            cnt_reg         <= cnt_next;
            rd_ptr_reg      <= rd_ptr_next;
            mv_valid_reg    <= mv_valid_next;
            mv_addr_reg     <= mv_addr_next;
            byp_reg         <= byp_next;
            byp_data_reg    <= byp_data_next;
            pend_value_reg  <= pend_value_next;
            pend_status_reg <= pend_status_next;
            res_valid_reg   <= res_valid_next;
            res_value_reg   <= res_value_next;
            res_status_reg  <= res_status_next;
        end
    end

endmodule

// File: rtl/core/tssr_checker.sv
// tssr_checker: port-level checks for three_stacks_shared_ring
// depends on tssr_pkg; bound to the top level at the end of this file
module tssr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        request_valid,
    input logic        request_ready,
    input logic [1:0]  stack_select,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] pop_value,
    input logic [1:0]  status
);

    import tssr_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(pop_value) && $stable(status))
        else $error("result changed while stalled");

    // only a good pop carries data
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |-> pop_value == '0)
        else $error("error result with nonzero data");

    // reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !result_valid && request_ready)
        else $error("not idle in reset");

    // a bad stack number is answered at once when the output is free
    a_invalid_fast: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && request_ready && stack_select == SEL_INVALID
            && (!result_valid || result_ready) |=>
            result_valid && status == ST_INVALID)
        else $error("invalid stack not reported");

endmodule

bind three_stacks_shared_ring tssr_checker u_tssr_checker (.*);

// File: verif/tb_three_stacks_shared_ring.sv
// tb_three_stacks_shared_ring: self-checking bench for three stacks sharing one ring
// directed request table followed by phased random traffic, checked by a ring predictor
// depends on tssr_pkg and the three_stacks_shared_ring rtl
module tb_three_stacks_shared_ring;

    timeunit 1ns;
    timeprecision 1ps;

    import tssr_pkg::*;

    localparam int STACK_DEPTH   = DEF_STACK_DEPTH;
    localparam int WORD_WIDTH    = DEF_WORD_WIDTH;
    localparam int RING_WORDS    = NUM_STACKS * STACK_DEPTH;
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int NUM_DIRECTED  = 20;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int SEGMENT_LEN   = 150;
    localparam int NUM_WEIGHTS   = 6;
    // a shift can walk nearly the whole ring, give the tail room for that
    localparam int TAIL_CYCLES   = 300;
    localparam int LIMIT_CYCLES  = 1500000;

    typedef struct packed {
        logic [31:0] pop_value;
        logic [1:0]  status;
    } ring_result_t;

    // answer typed into the table, or left to the predictor
    typedef struct packed {
        bit           typed;
        ring_result_t res;
    } table_answer_t;

    typedef struct packed {
        logic         operation;
        logic [1:0]   stack_select;
        logic [31:0]  push_value;
        bit           typed;
        ring_result_t res;
    } request_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        request_valid;
    logic        request_ready;
    logic        operation;
    logic [1:0]  stack_select;
    logic [31:0] push_value;
    logic        result_valid;
    logic        result_ready;
    logic [31:0] pop_value;
    logic [1:0]  status;

    // predictor copy of the ring and its pointers
    logic [31:0] ring_words [RING_WORDS];
    int unsigned stack_top  [NUM_STACKS];
    int unsigned stack_base [NUM_STACKS];

    ring_result_t  expected_results [$];
    table_answer_t table_answers    [$];

    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned requests_sent  = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;

    request_row_t directed_rows [NUM_DIRECTED];
    int unsigned  push_weights  [NUM_WEIGHTS] = '{90, 85, 55, 15, 10, 70};

    three_stacks_shared_ring #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .operation     (operation),
        .stack_select  (stack_select),
        .push_value    (push_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .pop_value     (pop_value),
        .status        (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog: a hung handshake ends the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[three_stacks_shared_ring] ERROR");
            $finish;
        end
    end

    // ring arithmetic, everything modulo the ring size
    function automatic int unsigned ring_fwd(int unsigned a, int unsigned b);
        return (a + b) % RING_WORDS;
    endfunction

    function automatic int unsigned ring_back(int unsigned a, int unsigned b);
        return (a + RING_WORDS - b) % RING_WORDS;
    endfunction

    // move stack j up by half its free gap, rounded down, plus one; 0 when it abuts the next one
    function automatic bit make_room(int unsigned j);
        int unsigned after;
        int unsigned gap;
        int unsigned shift_by;
        int unsigned count;
        int unsigned pos;
        after = (j + 1) % NUM_STACKS;
        if (stack_top[j] == stack_base[after])
            return 1'b0;
        gap      = ring_back(stack_base[after], stack_top[j]);
        shift_by = (gap + 2) / 2;
        count    = ring_back(stack_top[j], stack_base[j]);
        // topmost word first so nothing is overwritten before it moves
        for (int unsigned k = 0; k < count; k++)
        begin
            pos = ring_back(stack_top[j], k + 1);
            ring_words[ring_fwd(pos, shift_by)] = ring_words[pos];
        end
        stack_base[j] = ring_fwd(stack_base[j], shift_by);
        stack_top[j]  = ring_fwd(stack_top[j], shift_by);
        return 1'b1;
    endfunction

    // one request against the predictor state, returns its result
    function automatic ring_result_t predict_result(logic op, logic [1:0] sel,
                                                    logic [31:0] value);
        ring_result_t res;
        int unsigned  s;
        int unsigned  next;
        logic [31:0]  word_mask;
        word_mask     = (WORD_WIDTH >= 32) ? '1 : ((32'd1 << WORD_WIDTH) - 1);
        res.pop_value = '0;
        res.status    = ST_OK;
        s             = sel;
        if (sel == SEL_INVALID)
            res.status = ST_INVALID;
        else if (op == OP_PUSH)
        begin
            next = (s + 1) % NUM_STACKS;
            // reaching the next base forces that stack to make room first
            if (stack_top[s] == stack_base[next] && !make_room(next))
                res.status = ST_OVERFLOW;
            else
            begin
                ring_words[stack_top[s]] = value & word_mask;
                stack_top[s] = ring_fwd(stack_top[s], 1);
            end
        end
        else if (stack_top[s] == stack_base[s])
            res.status = ST_UNDERFLOW;
        else
        begin
            stack_top[s]  = ring_back(stack_top[s], 1);
            res.pop_value = ring_words[stack_top[s]] & word_mask;
        end
        return res;
    endfunction

    // receiver side: ready toggles at random per the current idle share
    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    // monitor: requests are predicted before results are checked at the same edge,
    // so the order of processes within a step does not matter
    always @(posedge clk)
    begin : monitor
        table_answer_t answer;
        ring_result_t  predicted;
        ring_result_t  oldest;
        if (rst_n && request_valid && request_ready)
        begin
            predicted = predict_result(operation, stack_select, push_value);
            if (table_answers.size() == 0)
            begin
                $error("request accepted while none was offered");
                fail_count++;
            end
            else
            begin
                answer = table_answers.pop_front();
                expected_results.push_back(answer.typed ? answer.res : predicted);
            end
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: pop_value %h status %0d",
                       pop_value, status);
                fail_count++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (pop_value !== oldest.pop_value)
                begin
                    $error("pop_value expected %h actual %h", oldest.pop_value, pop_value);
                    fail_count++;
                end
                if (status !== oldest.status)
                begin
                    $error("status expected %0d actual %0d", oldest.status, status);
                    fail_count++;
                end
            end
        end
    end

    // offer one request, hold it until accepted
    task automatic send_request(logic op, logic [1:0] sel, logic [31:0] value,
                                bit typed, ring_result_t res);
        int unsigned total;
        total = NUM_DIRECTED + RANDOM_ITEMS;
        // idle phases: receiver sparse first, then sender sparse, then full speed
        if (requests_sent < total / 3)
        begin
            send_idle_pct = 34;
            recv_idle_pct = 78;
        end
        else if (requests_sent < (2 * total) / 3)
        begin
            send_idle_pct = 78;
            recv_idle_pct = 34;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        table_answers.push_back('{typed: typed, res: res});
        while ($urandom_range(99) < send_idle_pct)
        begin
            request_valid <= 1'b0;
            @(posedge clk);
        end
        request_valid <= 1'b1;
        operation     <= op;
        stack_select  <= sel;
        push_value    <= value;
        do
            @(posedge clk);
        while (!request_ready);
        requests_sent++;
    endtask

    // mostly valid stacks, a few invalid selects as noise, optional favorite
    function automatic logic [1:0] pick_stack(bit has_fav, logic [1:0] fav);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return SEL_INVALID;
        if (has_fav && r < 50)
            return fav;
        return 2'($urandom_range(NUM_STACKS - 1));
    endfunction

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(99);
        case (r)
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        ring_result_t none;
        int unsigned  push_pct;
        bit           has_fav;
        logic [1:0]   fav;
        logic         op;
        none = '0;

        rst_n         = 1'b0;
        request_valid = 1'b0;
        operation     = OP_PUSH;
        stack_select  = '0;
        push_value    = '0;
        result_ready  = 1'b0;
        for (int k = 0; k < NUM_STACKS; k++)
        begin
            stack_top[k]  = k * STACK_DEPTH;
            stack_base[k] = k * STACK_DEPTH;
        end

        // directed rows: empty pops, invalid select, word extremes, lifo order;
        // the last rows are left to the predictor
        directed_rows = '{
            '{OP_POP,  2'd0,        32'h0000_0000, 1'b1, '{32'h0, ST_UNDERFLOW}},
            '{OP_POP,  2'd1,        32'hffff_ffff, 1'b1, '{32'h0, ST_UNDERFLOW}},
            '{OP_POP,  2'd2,        32'h0000_0000, 1'b1, '{32'h0, ST_UNDERFLOW}},
            '{OP_PUSH, SEL_INVALID, 32'hffff_ffff, 1'b1, '{32'h0, ST_INVALID}},
            '{OP_POP,  SEL_INVALID, 32'h0000_0000, 1'b1, '{32'h0, ST_INVALID}},
            '{OP_PUSH, 2'd0,        32'h7fff_ffff, 1'b1, '{32'h0, ST_OK}},
            '{OP_PUSH, 2'd0,        32'h8000_0000, 1'b1, '{32'h0, ST_OK}},
            '{OP_POP,  2'd0,        32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK}},
            '{OP_POP,  2'd0,        32'h0000_0000, 1'b1, '{32'h7fff_ffff, ST_OK}},
            '{OP_POP,  2'd0,        32'h0000_0000, 1'b1, '{32'h0, ST_UNDERFLOW}},
            '{OP_PUSH, 2'd2,        32'hffff_ffff, 1'b1, '{32'h0, ST_OK}},
            '{OP_PUSH, 2'd2,        32'h0000_0000, 1'b1, '{32'h0, ST_OK}},
            '{OP_PUSH, 2'd1,        32'ha5a5_a5a5, 1'b1, '{32'h0, ST_OK}},
            '{OP_POP,  2'd2,        32'hffff_ffff, 1'b1, '{32'h0, ST_OK}},
            '{OP_POP,  2'd1,        32'h0000_0000, 1'b1, '{32'ha5a5_a5a5, ST_OK}},
            '{OP_POP,  2'd2,        32'h0000_0000, 1'b1, '{32'hffff_ffff, ST_OK}},
            '{OP_PUSH, 2'd1,        32'h5a5a_5a5a, 1'b0, '{32'h0, ST_OK}},
            '{OP_PUSH, 2'd0,        32'h1234_5678, 1'b0, '{32'h0, ST_OK}},
            '{OP_POP,  2'd1,        32'h0000_0000, 1'b0, '{32'h0, ST_OK}},
            '{OP_POP,  2'd0,        32'h0000_0000, 1'b0, '{32'h0, ST_OK}}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].operation, directed_rows[i].stack_select,
                         directed_rows[i].push_value, directed_rows[i].typed,
                         directed_rows[i].res);

        // random part in segments; heavy push segments fill the ring up to
        // overflow and force shifts across the wrap, pop-heavy ones drain it
        // into underflow; a favorite stack lets one stack sweep the ring
        push_pct = push_weights[0];
        has_fav  = 1'b0;
        fav      = 2'd0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % SEGMENT_LEN == 0)
            begin
                push_pct = push_weights[(i / SEGMENT_LEN) % NUM_WEIGHTS];
                has_fav  = $urandom_range(1);
                fav      = 2'($urandom_range(NUM_STACKS - 1));
            end
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            send_request(op, pick_stack(has_fav, fav), pick_word(), 1'b0, none);
        end
        request_valid <= 1'b0;

        // drain: every request owes exactly one result
        while (expected_results.size() != 0 || table_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("[three_stacks_shared_ring] OK");
        else
            $display("[three_stacks_shared_ring] ERROR");
        $finish;
    end

endmodule
